// File: rtl/rag_pkg.sv
// Shared types and constants for the ragged gather unit.
// Used by every module under rtl; depends on nothing.
package rag_pkg;

  typedef enum logic [1:0] {
    ACT_WR_OFFSET = 2'd0,
    ACT_WR_COUNTS = 2'd1,
    ACT_WR_VALUE  = 2'd2,
    ACT_GATHER    = 2'd3
  } action_e;

  // Configuration register index, taken from paddr[2]
  localparam logic REG_DROP_ENABLE = 1'b0;
  localparam logic REG_PAD_ENABLE  = 1'b1;

  localparam int unsigned CntWidth  = 13;
  localparam int unsigned ColWidth  = 14;
  // Signed width that holds begin + column + drop - pad with margin
  localparam int unsigned IdxWidth  = 17;

  typedef struct packed {
    logic drop_en;
    logic pad_en;
  } cfg_t;

  // Row fetch results handed to the value stage
  typedef struct packed {
    logic                       valid;
    logic                       row_ok;
    logic signed [ColWidth-1:0] col;
    logic [CntWidth-1:0]        beg;
    logic [CntWidth-1:0]        fin;
    logic [CntWidth-1:0]        drop;
    logic [CntWidth-1:0]        pad;
  } row_fetch_t;

endpackage

// File: rtl/rag_cfg_regs.sv
// APB-style configuration registers: drop and pad enables.
// Depends on rag_pkg.
module rag_cfg_regs (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [2:0]        paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready,
  output rag_pkg::cfg_t     cfg_o
);

  rag_pkg::cfg_t cfg_q, cfg_d;
  logic          wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite;

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      unique case (paddr[2])
        rag_pkg::REG_DROP_ENABLE: cfg_d.drop_en = pwdata[0];
        rag_pkg::REG_PAD_ENABLE:  cfg_d.pad_en  = pwdata[0];
        default:                  cfg_d = cfg_q;
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    unique case (paddr[2])
      rag_pkg::REG_DROP_ENABLE: prdata[0] = cfg_q.drop_en;
      rag_pkg::REG_PAD_ENABLE:  prdata[0] = cfg_q.pad_en;
      default:                  prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

// File: rtl/rag_row_fetch.sv
// Row tables: offset memory (two read ports) and drop/pad count memory.
// Writes and gather reads happen at the accept edge. Depends on rag_pkg.
module rag_row_fetch #(
  parameter int unsigned MAX_ROWS = 1024
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                accept_i,
  input  rag_pkg::action_e                    action_i,
  input  logic [11:0]                         table_index_i,
  input  logic [rag_pkg::CntWidth-1:0]        offset_word_i,
  input  logic [rag_pkg::CntWidth-1:0]        drop_count_i,
  input  logic [rag_pkg::CntWidth-1:0]        pad_count_i,
  input  logic [9:0]                          src_row_i,
  input  logic signed [rag_pkg::ColWidth-1:0] padded_index_i,
  output rag_pkg::row_fetch_t                 fetch_o
);

  localparam int unsigned OffDepth = MAX_ROWS + 1;
  localparam int unsigned OffAw    = $clog2(OffDepth);
  localparam int unsigned RowAw    = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
  localparam int unsigned Cw       = rag_pkg::CntWidth;

  logic [Cw-1:0]   off_mem [OffDepth];
  logic [2*Cw-1:0] cnt_mem [MAX_ROWS];

  logic [31:0]      slot_ext, row_ext, row_nxt_ext;
  logic             off_we, cnt_we, gather, row_ok;
  logic [OffAw-1:0] off_wa, off_ra0, off_ra1;
  logic [RowAw-1:0] cnt_wa, cnt_ra;

  logic                                valid_q, row_ok_q;
  logic signed [rag_pkg::ColWidth-1:0] col_q;
  logic [Cw-1:0]                       beg_q, fin_q;
  logic [2*Cw-1:0]                     cnt_q;

  assign slot_ext    = {20'd0, table_index_i};
  assign row_ext     = {22'd0, src_row_i};
  assign row_nxt_ext = row_ext + 32'd1;

  assign off_we = accept_i && (action_i == rag_pkg::ACT_WR_OFFSET) &&
                  (slot_ext <= 32'(MAX_ROWS));
  assign cnt_we = accept_i && (action_i == rag_pkg::ACT_WR_COUNTS) &&
                  (slot_ext < 32'(MAX_ROWS));
  assign gather = accept_i && (action_i == rag_pkg::ACT_GATHER);
  assign row_ok = row_ext < 32'(MAX_ROWS);

  assign off_wa  = slot_ext[OffAw-1:0];
  assign cnt_wa  = slot_ext[RowAw-1:0];
  // Out-of-range rows read entry zero; the row_ok flag discards the result
  assign off_ra0 = row_ok ? row_ext[OffAw-1:0]     : '0;
  assign off_ra1 = row_ok ? row_nxt_ext[OffAw-1:0] : '0;
  assign cnt_ra  = row_ok ? row_ext[RowAw-1:0]     : '0;

  always_ff @(posedge clk_i) begin
    if (off_we) begin
      off_mem[off_wa] <= offset_word_i;
    end
    if (cnt_we) begin
      cnt_mem[cnt_wa] <= {drop_count_i, pad_count_i};
    end
    if (gather) begin
      beg_q    <= off_mem[off_ra0];
      fin_q    <= off_mem[off_ra1];
      cnt_q    <= cnt_mem[cnt_ra];
      col_q    <= padded_index_i;
      row_ok_q <= row_ok;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= gather;
    end
  end

  always_comb begin
    fetch_o.valid  = valid_q;
    fetch_o.row_ok = row_ok_q;
    fetch_o.col    = col_q;
    fetch_o.beg    = beg_q;
    fetch_o.fin    = fin_q;
    fetch_o.drop   = cnt_q[2*Cw-1:Cw];
    fetch_o.pad    = cnt_q[Cw-1:0];
  end

endmodule

// File: rtl/rag_value_fetch.sv
// Index arithmetic, range check and the value store with its result register.
// Depends on rag_pkg.
module rag_value_fetch #(
  parameter int unsigned VALUE_DEPTH = 4096,
  parameter int unsigned VALUE_WIDTH = 32
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  rag_pkg::cfg_t       cfg_i,
  input  rag_pkg::row_fetch_t fetch_i,
  input  logic                wr_en_i,
  input  logic [11:0]         wr_slot_i,
  input  logic [31:0]         wr_word_i,
  output logic                result_valid_o,
  output logic [31:0]         gathered_value_o,
  output logic                in_range_o
);

  localparam int unsigned Aw = (VALUE_DEPTH > 1) ? $clog2(VALUE_DEPTH) : 1;
  localparam int unsigned Iw = rag_pkg::IdxWidth;
  localparam int unsigned Cw = rag_pkg::CntWidth;

  logic [VALUE_WIDTH-1:0] mem [VALUE_DEPTH];

  logic [31:0]            wslot_ext, idx_ext;
  logic [63:0]            wword_ext, rdata_ext;
  logic                   we, hit;
  logic signed [Iw-1:0]   beg_s, fin_s, drop_s, pad_s, col_s, idx;
  logic [Aw-1:0]          ra;

  logic                   valid_q, hit_q;
  logic [VALUE_WIDTH-1:0] data_q;

  assign wslot_ext = {20'd0, wr_slot_i};
  assign wword_ext = {32'd0, wr_word_i};
  assign we        = wr_en_i && (wslot_ext < 32'(VALUE_DEPTH));

  assign beg_s  = signed'({{(Iw-Cw){1'b0}}, fetch_i.beg});
  assign fin_s  = signed'({{(Iw-Cw){1'b0}}, fetch_i.fin});
  assign drop_s = cfg_i.drop_en ? signed'({{(Iw-Cw){1'b0}}, fetch_i.drop}) : '0;
  assign pad_s  = cfg_i.pad_en  ? signed'({{(Iw-Cw){1'b0}}, fetch_i.pad})  : '0;
  assign col_s  = Iw'(fetch_i.col);
  assign idx    = beg_s + col_s + drop_s - pad_s;

  // idx >= beg implies idx is non-negative, so the depth check may be unsigned
  assign idx_ext = {{(32-Iw){1'b0}}, idx};
  assign hit = fetch_i.row_ok && (idx >= beg_s) && (idx < fin_s) &&
               (idx_ext < 32'(VALUE_DEPTH));
  assign ra  = idx_ext[Aw-1:0];

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[wslot_ext[Aw-1:0]] <= wword_ext[VALUE_WIDTH-1:0];
    end
    if (fetch_i.valid && hit) begin
      data_q <= mem[ra];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      hit_q   <= 1'b0;
    end else begin
      valid_q <= fetch_i.valid;
      hit_q   <= fetch_i.valid && hit;
    end
  end

  always_comb begin
    rdata_ext                  = '0;
    rdata_ext[VALUE_WIDTH-1:0] = data_q;
  end

  assign result_valid_o   = valid_q;
  assign in_range_o       = hit_q;
  assign gathered_value_o = hit_q ? rdata_ext[31:0] : 32'd0;

endmodule

// File: rtl/ragged_gather_with_pad_drop_unit.sv
// Top level of the ragged gather unit: config port, row fetch, value fetch.
// Depends on rag_pkg, rag_cfg_regs, rag_row_fetch, rag_value_fetch.
//
//  channel  | handshake                  | words
//  ---------+----------------------------+---------------------------------------
//  command  | start_i / busy_o           | action, table_index, offsets, counts..
//  result   | result_valid_o (strobe)    | gathered_value_o, in_range_o
//  config   | psel/penable/pwrite/pready | pwdata -> drop_enable, pad_enable
//
// One command word is taken every cycle; busy_o stays low. A gather's result
// strobes once its row tables are read at the accept edge and the value store
// at the next edge after the index add and range compare; the result register
// holds the word until the next in-range gather. Writes produce no result.
// Reset clears only the enables, the pipeline valids and the hit flag; the
// stores hold nothing defined until written and need no clearing pass.
// The receiver cannot stall, so the pipeline never holds.
module ragged_gather_with_pad_drop_unit #(
  parameter int unsigned MAX_ROWS    = 1024,
  parameter int unsigned VALUE_DEPTH = 4096,
  parameter int unsigned VALUE_WIDTH = 32
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  // command channel
  input  logic               start_i,
  output logic               busy_o,
  input  logic [1:0]         action_i,
  input  logic [11:0]        table_index_i,
  input  logic [12:0]        offset_word_i,
  input  logic [12:0]        drop_count_i,
  input  logic [12:0]        pad_count_i,
  input  logic [31:0]        value_word_i,
  input  logic [9:0]         src_row_i,
  input  logic signed [13:0] padded_index_i,
  // result channel
  output logic               result_valid_o,
  output logic [31:0]        gathered_value_o,
  output logic               in_range_o,
  // configuration port
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [2:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);

  rag_pkg::cfg_t       cfg;
  rag_pkg::row_fetch_t fetch;
  rag_pkg::action_e    action;
  logic                accept;
  logic                value_we;

  // Every cycle can take a word: the pipeline has no backpressure
  assign busy_o   = 1'b0;
  assign accept   = start_i & ~busy_o;
  assign action   = rag_pkg::action_e'(action_i);
  assign value_we = accept && (action == rag_pkg::ACT_WR_VALUE);

  rag_cfg_regs u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  // Table writes land at the accept edge, the same edge gathers read at, so a
  // gather right after a write already sees it.
  rag_row_fetch #(
    .MAX_ROWS (MAX_ROWS)
  ) u_row (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .accept_i       (accept),
    .action_i       (action),
    .table_index_i  (table_index_i),
    .offset_word_i  (offset_word_i),
    .drop_count_i   (drop_count_i),
    .pad_count_i    (pad_count_i),
    .src_row_i      (src_row_i),
    .padded_index_i (padded_index_i),
    .fetch_o        (fetch)
  );

  // Value writes also land at the accept edge; a gather reads the value store at the
  // next edge, so a write taken after it is seen as not yet done, matching word order.
  rag_value_fetch #(
    .VALUE_DEPTH (VALUE_DEPTH),
    .VALUE_WIDTH (VALUE_WIDTH)
  ) u_val (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_i            (cfg),
    .fetch_i          (fetch),
    .wr_en_i          (value_we),
    .wr_slot_i        (table_index_i),
    .wr_word_i        (value_word_i),
    .result_valid_o   (result_valid_o),
    .gathered_value_o (gathered_value_o),
    .in_range_o       (in_range_o)
  );

endmodule
